[src/pvrl_pkg.sv]
// Shared types, register codes and helpers for the velocity ramp limiter.
package pvrl_pkg;

  localparam int NUM_PT_REGS = 6;

  // Configuration register indexes
  localparam logic [2:0] REG_PT_ZERO  = 3'd0;
  localparam logic [2:0] REG_PTS_USED = 3'd6;
  localparam logic [2:0] REG_REVERSE  = 3'd7;

  // Reset value of each ramp point register: {threshold, acceleration}
  localparam logic [31:0] PT_DEFAULT [NUM_PT_REGS] = '{
    32'hFFFF01F4, 32'h00640050, 32'h012C0046,
    32'h04B0003C, 32'h0960003C, 32'h0BB8001E
  };

  localparam logic [2:0] PTS_USED_RESET = 3'd6;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_CALC,
    ST_FINAL
  } pvrl_state_t;

  // Controller to datapath
  typedef struct packed {
    logic load;
    logic scan_step;
    logic calc;
    logic out_load;
  } pvrl_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic scan_done;
    logic out_free;
  } pvrl_stat_t;

  // Negation that maps the most negative value to the most positive one
  function automatic logic signed [15:0] sat_neg(input logic signed [15:0] v);
    logic signed [15:0] r;
    if (v == 16'sh8000) begin
      r = 16'sh7FFF;
    end else begin
      r = -v;
    end
    return r;
  endfunction

endpackage

[src/pvrl_regs.sv]
// Configuration registers: ramp point table, points in use and direction.
module pvrl_regs #(
  parameter int RAMP_POINTS = 6,
  parameter int IX_W = 3
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_valid,
  input  logic              cfg_ready,
  input  logic [2:0]        cfg_index,
  input  logic [31:0]       cfg_data,
  input  logic [IX_W-1:0]   pt_ix,
  output logic [31:0]       pt_sel,
  output logic [IX_W-1:0]   pt_last,
  output logic              reverse
);
  import pvrl_pkg::*;

  localparam logic [4:0] NPTS = 5'(RAMP_POINTS);

  logic [31:0] pts [RAMP_POINTS];
  logic [2:0]  pts_used;
  logic [4:0]  used_ext;
  logic [4:0]  used_lim;
  logic        wr;

  assign wr = cfg_valid && cfg_ready;

  // Point table; entries past the register list keep the last default
  always_ff @(posedge clk) begin
    for (int i = 0; i < RAMP_POINTS; i++) begin
      if (rst) begin
        pts[i] <= PT_DEFAULT[(i < NUM_PT_REGS) ? i : NUM_PT_REGS - 1];
      end else if (wr && i < NUM_PT_REGS && 32'(cfg_index) == i) begin
        pts[i] <= cfg_data;
      end
    end
  end

  // Scalar registers
  always_ff @(posedge clk) begin
    if (rst) begin
      pts_used <= PTS_USED_RESET;
      reverse  <= 1'b0;
    end else if (wr) begin
      unique case (cfg_index)
        REG_PTS_USED: pts_used <= cfg_data[2:0];
        REG_REVERSE:  reverse  <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // Clamp points in use to 1..RAMP_POINTS, report last usable index
  always_comb begin
    used_ext = {2'b00, pts_used};
    if (used_ext == 5'd0) begin
      used_lim = 5'd1;
    end else if (used_ext > NPTS) begin
      used_lim = NPTS;
    end else begin
      used_lim = used_ext;
    end
  end

  assign pt_last = IX_W'(used_lim - 5'd1);
  assign pt_sel  = pts[pt_ix];

endmodule

[src/pvrl_ctrl.sv]
// Sequencer: accepts a transaction, walks the ramp scan, hands off the result.
module pvrl_ctrl (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  input  logic                  func,
  output logic                  in_stall,
  input  pvrl_pkg::pvrl_stat_t  stat,
  output pvrl_pkg::pvrl_cmd_t   cmd
);
  import pvrl_pkg::*;

  pvrl_state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_stall   = 1'b1;
    unique case (state)
      ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.load   = 1'b1;
          // set-target goes straight to the report
          state_next = func ? ST_SCAN : ST_FINAL;
        end
      end
      ST_SCAN: begin
        if (stat.scan_done) begin
          state_next = ST_CALC;
        end else begin
          cmd.scan_step = 1'b1;
        end
      end
      ST_CALC: begin
        cmd.calc   = 1'b1;
        state_next = ST_FINAL;
      end
      ST_FINAL: begin
        if (stat.out_free) begin
          cmd.out_load = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

endmodule

[src/pvrl_dp.sv]
// Datapath: target and mode state, ramp scan, limited command and output register.
module pvrl_dp #(
  parameter int IX_W = 3
) (
  input  logic                  clk,
  input  logic                  rst,
  input  pvrl_pkg::pvrl_cmd_t   cmd,
  output pvrl_pkg::pvrl_stat_t  stat,
  input  logic                  func,
  input  logic signed [15:0]    target_speed,
  input  logic signed [15:0]    measured_speed,
  input  logic [31:0]           pt_sel,
  input  logic [IX_W-1:0]       pt_last,
  input  logic                  reverse,
  output logic [IX_W-1:0]       pt_ix,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic                  is_command,
  output logic                  velocity_mode,
  output logic signed [15:0]    speed_command
);
  import pvrl_pkg::*;

  logic               func_q;
  logic signed [15:0] stored_target;
  logic               mode_flag;
  logic signed [15:0] speed;
  logic signed [15:0] cmd_val;
  logic signed [15:0] thr;
  logic               above;
  logic signed [16:0] diff;
  logic signed [17:0] sum;
  logic signed [15:0] sum_sat;
  logic signed [15:0] limited;
  logic signed [15:0] final_cmd;

  function automatic logic signed [16:0] target_sext(input logic signed [15:0] v);
    return {v[15], v};
  endfunction

  // Target and mode: control state
  always_ff @(posedge clk) begin
    if (rst) begin
      stored_target <= '0;
      mode_flag     <= 1'b0;
    end else if (cmd.load && !func) begin
      stored_target <= target_speed;
      mode_flag     <= (target_speed != 16'sd0);
    end
  end

  // Capture of the incoming transaction, scan index
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      func_q <= func;
      speed  <= reverse ? sat_neg(measured_speed) : measured_speed;
      pt_ix  <= '0;
    end else if (cmd.scan_step) begin
      pt_ix <= pt_ix + IX_W'(1);
    end
  end

  // One ramp point compared per cycle
  assign thr   = $signed(pt_sel[31:16]);
  assign above = speed > thr;
  assign stat.scan_done = (pt_ix == pt_last) || !above;

  // Acceleration limit with the selected point
  always_comb begin
    diff    = 17'(target_sext(stored_target)) - 17'(target_sext(speed));
    sum     = 18'(speed) + $signed({2'b00, pt_sel[15:0]});
    sum_sat = (sum > 18'sd32767) ? 16'sh7FFF : sum[15:0];
    if (stored_target > speed && diff > $signed({1'b0, pt_sel[15:0]})) begin
      limited = sum_sat;
    end else begin
      limited = stored_target;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.calc) begin
      cmd_val <= limited;
    end
  end

  assign final_cmd = reverse ? sat_neg(cmd_val) : cmd_val;

  // Output register: takes a result while the previous one leaves
  assign stat.out_free = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      is_command    <= func_q;
      velocity_mode <= mode_flag;
      speed_command <= func_q ? final_cmd : 16'sd0;
    end
  end

endmodule

[src/piecewise_velocity_ramp_limiter_core.sv]
// Top level of the piecewise velocity ramp limiter.
// A set-target transaction (func 0) stores the target and returns a mode report
// (stopped for a zero target, velocity otherwise); the report is loaded into the
// output register from the final state once that register is free, and the next
// transaction can be taken once that load has happened.
// A tick transaction (func 1) scans the ramp table one point per cycle until it
// finds the first point whose threshold the measured speed does not exceed, or
// the last point in use, and then limits acceleration by that point; the limited
// command is registered in the calc state and loaded into the output register
// from the final state, after which the next transaction can be taken.
// One transaction is in work at a time; a finished result waits in the output
// register while the next transaction is accepted. Configuration writes are
// always taken and must only be issued while the block is idle.
module piecewise_velocity_ramp_limiter_core #(
  parameter int RAMP_POINTS = 6
) (
  input  logic               clk,
  input  logic               rst,
  // input channel
  input  logic               in_valid,
  output logic               in_stall,
  input  logic               func,
  input  logic signed [15:0] target_speed,
  input  logic signed [15:0] measured_speed,
  // output channel
  output logic               out_valid,
  input  logic               out_stall,
  output logic               is_command,
  output logic               velocity_mode,
  output logic signed [15:0] speed_command,
  // configuration writes
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [2:0]         cfg_index,
  input  logic [31:0]        cfg_data
);
  import pvrl_pkg::*;

  localparam int IX_W = (RAMP_POINTS > 1) ? $clog2(RAMP_POINTS) : 1;

  pvrl_cmd_t        cmd;
  pvrl_stat_t       stat;
  logic [31:0]      pt_sel;
  logic [IX_W-1:0]  pt_last;
  logic [IX_W-1:0]  pt_ix;
  logic             reverse;

  assign cfg_ready = 1'b1;

  pvrl_regs #(
    .RAMP_POINTS (RAMP_POINTS),
    .IX_W        (IX_W)
  ) u_regs (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .pt_ix     (pt_ix),
    .pt_sel    (pt_sel),
    .pt_last   (pt_last),
    .reverse   (reverse)
  );

  pvrl_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .func     (func),
    .in_stall (in_stall),
    .stat     (stat),
    .cmd      (cmd)
  );

  pvrl_dp #(
    .IX_W (IX_W)
  ) u_dp (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .stat           (stat),
    .func           (func),
    .target_speed   (target_speed),
    .measured_speed (measured_speed),
    .pt_sel         (pt_sel),
    .pt_last        (pt_last),
    .reverse        (reverse),
    .pt_ix          (pt_ix),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .is_command     (is_command),
    .velocity_mode  (velocity_mode),
    .speed_command  (speed_command)
  );

endmodule

[tb/tb_piecewise_velocity_ramp_limiter_core.sv]
// Self-checking testbench for the piecewise velocity ramp limiter core.
`timescale 1ns / 1ps

module tb_piecewise_velocity_ramp_limiter_core;
  import pvrl_pkg::*;

  localparam int RAMP_POINTS = 6;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int DRAIN_CYCLES = RAMP_POINTS + 12;
  localparam int RESET_CYCLES = 9;
  localparam int PHASES = 12;
  localparam int ITEMS_PER_PHASE = 125;
  localparam int MAX_REPORTS = 10;

  localparam logic FUNC_SET  = 1'b0;
  localparam logic FUNC_TICK = 1'b1;

  // Idle percentages per traffic mode
  localparam int IDLE_HEAVY = 60;
  localparam int IDLE_BOTH  = 34;

  typedef struct packed {
    logic               is_cmd;
    logic               mode;
    logic signed [15:0] cmd;
  } limiter_out_t;

  typedef enum logic {
    ROW_ITEM,
    ROW_REG
  } row_kind_t;

  typedef struct {
    row_kind_t          kind;
    logic               fn;
    logic signed [15:0] tgt;
    logic signed [15:0] meas;
    bit                 typed;
    limiter_out_t       res;
    logic [2:0]         idx;
    logic [31:0]        data;
  } stim_row_t;

  logic               clk = 1'b0;
  logic               rst;
  logic               in_valid;
  logic               in_stall;
  logic               func;
  logic signed [15:0] target_speed;
  logic signed [15:0] measured_speed;
  logic               out_valid;
  logic               out_stall;
  logic               is_command;
  logic               velocity_mode;
  logic signed [15:0] speed_command;
  logic               cfg_valid;
  logic               cfg_ready;
  logic [2:0]         cfg_index;
  logic [31:0]        cfg_data;

  // Shadow copy of the limiter state and its registers
  logic [31:0]        pt_table [RAMP_POINTS];
  logic [2:0]         pts_used_reg;
  logic               reverse_reg;
  logic signed [15:0] held_target;
  logic               held_mode;

  limiter_out_t limiter_outputs_due [$];
  int mismatch_count = 0;
  int idle_cycles = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;

  piecewise_velocity_ramp_limiter_core #(
    .RAMP_POINTS(RAMP_POINTS)
  ) u_dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .func(func),
    .target_speed(target_speed),
    .measured_speed(measured_speed),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .is_command(is_command),
    .velocity_mode(velocity_mode),
    .speed_command(speed_command),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  function automatic logic signed [15:0] clamp16(input int v);
    logic signed [15:0] r;
    if (v > 32767) begin
      r = 16'sh7FFF;
    end else if (v < -32768) begin
      r = 16'sh8000;
    end else begin
      r = 16'(v);
    end
    return r;
  endfunction

  // Next limiter output for one transaction; updates the shadow state
  function automatic limiter_out_t limit_ramp(input logic fn, input logic signed [15:0] tgt,
                                              input logic signed [15:0] meas);
    int spd;
    int accel;
    int cmd;
    int used;
    int ix;
    logic signed [15:0] thr;
    limiter_out_t r;
    if (fn == FUNC_SET) begin
      held_target = tgt;
      held_mode = (tgt != 16'sd0);
      r.is_cmd = 1'b0;
      r.mode = held_mode;
      r.cmd = 16'sd0;
    end else begin
      spd = int'(meas);
      if (reverse_reg) spd = int'(clamp16(-spd));
      used = int'(pts_used_reg);
      if (used < 1) used = 1;
      if (used > RAMP_POINTS) used = RAMP_POINTS;
      // first point whose threshold is not exceeded, else the last one in use
      ix = 0;
      thr = pt_table[0][31:16];
      while (ix + 1 < used && spd > int'(thr)) begin
        ix++;
        thr = pt_table[ix][31:16];
      end
      accel = int'({16'd0, pt_table[ix][15:0]});
      if (int'(held_target) > spd && int'(held_target) - spd > accel) begin
        cmd = int'(clamp16(spd + accel));
      end else begin
        cmd = int'(held_target);
      end
      if (reverse_reg) cmd = -cmd;
      r.is_cmd = 1'b1;
      r.mode = held_mode;
      r.cmd = clamp16(cmd);
    end
    return r;
  endfunction

  function automatic stim_row_t item_row(input logic fn, input logic signed [15:0] tgt,
                                         input logic signed [15:0] meas, input bit typed,
                                         input limiter_out_t res);
    stim_row_t row;
    row.kind = ROW_ITEM;
    row.fn = fn;
    row.tgt = tgt;
    row.meas = meas;
    row.typed = typed;
    row.res = res;
    row.idx = REG_PT_ZERO;
    row.data = 32'd0;
    return row;
  endfunction

  function automatic stim_row_t reg_row(input logic [2:0] idx, input logic [31:0] data);
    stim_row_t row;
    row = item_row(FUNC_SET, 16'sd0, 16'sd0, 1'b0, '0);
    row.kind = ROW_REG;
    row.idx = idx;
    row.data = data;
    return row;
  endfunction

  task automatic flag_failure(input string msg);
    mismatch_count++;
    if (mismatch_count <= MAX_REPORTS) $display("%s", msg);
  endtask

  // Present one transaction, with a possible random gap first; returns at the accepting edge
  task automatic send_item(input logic fn, input logic signed [15:0] tgt,
                           input logic signed [15:0] meas, input bit typed,
                           input limiter_out_t typed_res);
    limiter_out_t r;
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    in_valid <= 1'b1;
    func <= fn;
    target_speed <= tgt;
    measured_speed <= meas;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    r = limit_ramp(fn, tgt, meas);
    limiter_outputs_due.push_back(typed ? typed_res : r);
  endtask

  // Stop sending and wait until every outstanding output has come back
  task automatic settle_block();
    in_valid <= 1'b0;
    while (limiter_outputs_due.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [31:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    if (int'(idx) < NUM_PT_REGS) begin
      if (int'(idx) < RAMP_POINTS) pt_table[idx] = data;
    end else if (idx == REG_PTS_USED) begin
      pts_used_reg = data[2:0];
    end else if (idx == REG_REVERSE) begin
      reverse_reg = data[0];
    end
    @(posedge clk);
  endtask

  // Output monitor and receiver stall
  always @(posedge clk) begin
    limiter_out_t want;
    limiter_out_t got;
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        got = '{is_command, velocity_mode, speed_command};
        if (limiter_outputs_due.size() == 0) begin
          flag_failure($sformatf("unexpected output: is_command=%0d mode=%0d cmd=%0d",
                                 got.is_cmd, got.mode, got.cmd));
        end else begin
          want = limiter_outputs_due.pop_front();
          if (got !== want) begin
            flag_failure($sformatf(
              "mismatch: is_command %0d/%0d mode %0d/%0d cmd %0d/%0d (expected/actual)",
              want.is_cmd, got.is_cmd, want.mode, got.mode, want.cmd, got.cmd));
          end
        end
      end
      out_stall <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  // Watchdog on cycles with no transaction on any channel
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall) ||
        (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    stim_row_t rows [$];
    stim_row_t row;
    logic signed [15:0] tgt;
    logic signed [15:0] meas;
    logic [31:0] data;
    int thr_acc;
    int near;
    int mode;

    rst = 1'b1;
    in_valid = 1'b0;
    func = FUNC_SET;
    target_speed = 16'sd0;
    measured_speed = 16'sd0;
    cfg_valid = 1'b0;
    cfg_index = REG_PT_ZERO;
    cfg_data = 32'd0;
    for (int i = 0; i < RAMP_POINTS; i++) begin
      pt_table[i] = PT_DEFAULT[i < NUM_PT_REGS ? i : NUM_PT_REGS - 1];
    end
    pts_used_reg = PTS_USED_RESET;
    reverse_reg = 1'b0;
    held_target = 16'sd0;
    held_mode = 1'b0;

    // Directed part: reset state, extremes, threshold boundaries, register corners
    rows.push_back(item_row(FUNC_TICK, 16'sd0, 16'sd0, 1'b1,
                            limiter_out_t'{1'b1, 1'b0, 16'sd0}));
    rows.push_back(item_row(FUNC_SET, 16'sd0, 16'sd0, 1'b1,
                            limiter_out_t'{1'b0, 1'b0, 16'sd0}));
    rows.push_back(item_row(FUNC_SET, 16'sh7FFF, 16'sh8000, 1'b1,
                            limiter_out_t'{1'b0, 1'b1, 16'sd0}));
    rows.push_back(item_row(FUNC_TICK, 16'sh8000, 16'sh8000, 1'b0, '0));
    rows.push_back(item_row(FUNC_TICK, 16'sh7FFF, 16'sh7FFF, 1'b0, '0));
    rows.push_back(item_row(FUNC_TICK, -16'sd1, 16'sd32000, 1'b0, '0));
    rows.push_back(item_row(FUNC_SET, 16'sh8000, 16'sh7FFF, 1'b1,
                            limiter_out_t'{1'b0, 1'b1, 16'sd0}));
    rows.push_back(item_row(FUNC_TICK, 16'sd0, 16'sh7FFF, 1'b0, '0));
    rows.push_back(item_row(FUNC_SET, 16'sd1000, 16'sd0, 1'b1,
                            limiter_out_t'{1'b0, 1'b1, 16'sd0}));
    rows.push_back(item_row(FUNC_TICK, 16'sd0, 16'sd100, 1'b0, '0));
    rows.push_back(item_row(FUNC_TICK, 16'sd0, 16'sd101, 1'b0, '0));
    rows.push_back(item_row(FUNC_TICK, 16'sd0, -16'sd1, 1'b0, '0));
    rows.push_back(item_row(FUNC_TICK, 16'sd0, 16'sd0, 1'b0, '0));
    // reversed direction, most negative speed on both ends
    rows.push_back(reg_row(REG_REVERSE, 32'd1));
    rows.push_back(item_row(FUNC_TICK, 16'sd0, 16'sh8000, 1'b0, '0));
    rows.push_back(item_row(FUNC_SET, 16'sh8000, 16'sd0, 1'b1,
                            limiter_out_t'{1'b0, 1'b1, 16'sd0}));
    rows.push_back(item_row(FUNC_TICK, 16'sd0, 16'sd0, 1'b0, '0));
    // zero points in use acts as one, above the table size acts as the full table
    rows.push_back(reg_row(REG_PTS_USED, 32'd0));
    rows.push_back(item_row(FUNC_SET, 16'sd5000, 16'sd0, 1'b1,
                            limiter_out_t'{1'b0, 1'b1, 16'sd0}));
    rows.push_back(item_row(FUNC_TICK, 16'sd0, 16'sd2000, 1'b0, '0));
    rows.push_back(reg_row(REG_PTS_USED, 32'd7));
    rows.push_back(item_row(FUNC_TICK, 16'sd0, -16'sd2000, 1'b0, '0));
    // widest thresholds and accelerations
    rows.push_back(reg_row(REG_PT_ZERO + 3'd5, 32'h7FFF_FFFF));
    rows.push_back(reg_row(REG_REVERSE, 32'd0));
    rows.push_back(item_row(FUNC_SET, 16'sh7FFF, 16'sd0, 1'b1,
                            limiter_out_t'{1'b0, 1'b1, 16'sd0}));
    rows.push_back(item_row(FUNC_TICK, 16'sd0, 16'sh8000, 1'b0, '0));
    rows.push_back(reg_row(REG_PT_ZERO, 32'h8000_FFFF));
    rows.push_back(item_row(FUNC_TICK, 16'sd0, 16'sh8000, 1'b0, '0));
    rows.push_back(item_row(FUNC_TICK, 16'sd0, -16'sd32767, 1'b0, '0));
    rows.push_back(item_row(FUNC_SET, 16'sd0, 16'sd0, 1'b1,
                            limiter_out_t'{1'b0, 1'b0, 16'sd0}));

    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;

    foreach (rows[i]) begin
      row = rows[i];
      if (row.kind == ROW_REG) begin
        settle_block();
        write_reg(row.idx, row.data);
      end else begin
        send_item(row.fn, row.tgt, row.meas, row.typed, row.res);
      end
    end

    // Random phases: new register settings, then mixed set and tick traffic
    for (int phase = 0; phase < PHASES; phase++) begin
      settle_block();
      mode = phase % 4;
      send_idle_pct = (mode == 1) ? IDLE_HEAVY : (mode == 3) ? IDLE_BOTH : 0;
      recv_stall_pct = (mode == 2) ? IDLE_HEAVY : (mode == 3) ? IDLE_BOTH : 0;

      thr_acc = int'($urandom_range(0, 6000)) - 3000;
      for (int r = 0; r < NUM_PT_REGS; r++) begin
        if (phase == 0) begin
          data = 32'd0;
        end else if (phase == 1) begin
          data = '1;
        end else if (phase % 3 == 2) begin
          data = $urandom;
        end else begin
          // ascending thresholds, modest accelerations
          data = {clamp16(thr_acc), 16'($urandom_range(0, 1500))};
          thr_acc += int'($urandom_range(0, 8000));
        end
        write_reg(REG_PT_ZERO + 3'(r), data);
      end
      if (phase == 0) begin
        data = 32'd0;
      end else if (phase == 1) begin
        data = '1;
      end else begin
        data = ($urandom & ~32'h7) | 32'($urandom_range(0, 7));
      end
      write_reg(REG_PTS_USED, data);
      write_reg(REG_REVERSE, (phase < 2) ? data : $urandom);

      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        if ($urandom_range(99) < 25) begin
          case ($urandom_range(3))
            0: tgt = 16'sd0;
            1: tgt = 16'($urandom);
            default: tgt = clamp16(int'($urandom_range(0, 8000)) - 4000);
          endcase
          send_item(FUNC_SET, tgt, 16'($urandom), 1'b0, '0);
        end else begin
          // measured speed mostly around the target, seen in the motor's direction
          near = reverse_reg ? -int'(held_target) : int'(held_target);
          if ($urandom_range(3) == 0) begin
            meas = 16'($urandom);
          end else begin
            meas = clamp16(near + int'($urandom_range(0, 6000)) - 3000);
          end
          send_item(FUNC_TICK, 16'($urandom), meas, 1'b0, '0);
        end
      end
    end

    settle_block();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && limiter_outputs_due.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

[filelist.f]
src/pvrl_pkg.sv
src/pvrl_regs.sv
src/pvrl_ctrl.sv
src/pvrl_dp.sv
src/piecewise_velocity_ramp_limiter_core.sv
tb/tb_piecewise_velocity_ramp_limiter_core.sv
